@@ rtl/rms_pkg.sv @@
// Shared types, codes and constants of the running median store.
`default_nettype none

package rms_pkg;

  localparam int DATA_W = 64;
  // Per-cell tap toward the selection tree: {upper middle, lower middle, found}.
  localparam int TAP_W = 2 * DATA_W + 1;
  // Selection tree merges 2**FANIN_LOG nodes per registered level.
  localparam int FANIN_LOG = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  localparam logic MODE_UPPER = 1'b0;
  localparam logic MODE_MEAN  = 1'b1;

  // Commit strobes broadcast to every cell.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

  // Flags handed from one cell to its right neighbor.
  typedef struct packed {
    logic lt;  // stored value greater than the item value
    logic ge;  // stored value not less than the item value
  } nbr_t;

  // Number of registered levels of the selection tree for n leaves.
  function automatic int tree_levels(int n);
    return ($clog2(n) + FANIN_LOG - 1) / FANIN_LOG;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rms_cell.sv @@
// One storage cell of the sorted chain: holds one sample and shifts with its neighbors.
`default_nettype none

module rms_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 11
) (
  input  logic                      clk_i,
  input  rms_pkg::cell_ctrl_t       ctrl_i,
  input  logic [rms_pkg::DATA_W-1:0] item_val_i,
  input  logic [CNT_W-1:0]          cnt_i,
  input  logic [CNT_W-1:0]          lo_idx_i,
  input  logic [CNT_W-1:0]          hi_idx_i,
  input  logic [rms_pkg::DATA_W-1:0] left_val_i,
  input  rms_pkg::nbr_t             left_flags_i,
  input  logic [rms_pkg::DATA_W-1:0] right_val_i,
  output logic [rms_pkg::DATA_W-1:0] val_o,
  output rms_pkg::nbr_t             flags_o,
  output logic [rms_pkg::TAP_W-1:0] tap_o
);
  import rms_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] val_d;
  logic              occ;
  logic              first_free;
  logic              eq;
  logic              found;

  assign occ        = MY_IDX < cnt_i;
  assign first_free = MY_IDX == cnt_i;

  assign flags_o.lt = occ && ($signed(item_val_i) < $signed(val_q));
  assign flags_o.ge = occ && !($signed(val_q) < $signed(item_val_i));
  assign eq         = occ && (val_q == item_val_i);
  // First cell at or above the item value decides whether it is present.
  assign found      = eq && !left_flags_i.ge;

  assign tap_o = {(MY_IDX == lo_idx_i) ? val_q : {DATA_W{1'b0}},
                  (MY_IDX == hi_idx_i) ? val_q : {DATA_W{1'b0}},
                  found};

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins_en) begin
      if (left_flags_i.lt) begin
        val_d = left_val_i;
      end else if (flags_o.lt || first_free) begin
        val_d = item_val_i;
      end
    end else if (ctrl_i.rem_en) begin
      if (flags_o.ge) begin
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

@@ rtl/rms_or_tree.sv @@
// Registered OR tree that gathers the one-hot taps of all cells.
`default_nettype none

module rms_or_tree #(
  parameter int N = 1024,
  parameter int W = 129
) (
  input  logic         clk_i,
  input  logic [W-1:0] leaf_i [N],
  output logic [W-1:0] root_o
);
  import rms_pkg::*;

  localparam int LEVELS = tree_levels(N);
  localparam int FANIN  = 1 << FANIN_LOG;

  function automatic int lvl_cnt(int l);
    return (N + (1 << (FANIN_LOG * l)) - 1) >> (FANIN_LOG * l);
  endfunction

  function automatic int lvl_off(int l);
    int s;
    s = 0;
    for (int k = 0; k < l; k++) begin
      s = s + lvl_cnt(k);
    end
    return s;
  endfunction

  localparam int TOTAL = lvl_off(LEVELS) + 1;

  wire [W-1:0] node [TOTAL];

  for (genvar j = 0; j < N; j++) begin : g_leaf
    assign node[j] = leaf_i[j];
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < lvl_cnt(l); j++) begin : g_node
      localparam int BASE = lvl_off(l - 1) + FANIN * j;
      localparam int REST = lvl_cnt(l - 1) - FANIN * j;
      localparam int CH   = (REST < FANIN) ? REST : FANIN;
      logic [W-1:0] node_d;
      logic [W-1:0] node_q;

      always_comb begin
        node_d = '0;
        for (int k = 0; k < CH; k++) begin
          node_d = node_d | node[BASE + k];
        end
      end

      always_ff @(posedge clk_i) begin
        node_q <= node_d;
      end

      assign node[lvl_off(l) + j] = node_q;
    end
  end

  assign root_o = node[TOTAL-1];

endmodule

`default_nettype wire

@@ rtl/running_median_store.sv @@
// Top level of the running median store: item control, cell chain, selection tree.
//
// Keeps a sorted multiset of up to CAPACITY signed 64-bit samples in a chain of
// cells, one sample per cell, and answers median queries.
// Input channel s_axis: tdata carries the sample, tuser the request kind and the
// null flag. Each item is an insert, a remove or a median query.
// Output channel m_axis: one result item per input item; tdata carries the median
// (zero unless a query succeeds), tuser the empty flag and the status code.
// Configuration: cfg_wr_en_i writes cfg_wr_data_i into the median mode register
// (1 = mean of the two middle samples, 0 = upper middle sample); write only when idle.
// Timing: one item at a time. Inserts and spare-code items commit once the output
// register is free; removes (null ones too) and queries first wait for the L = ceil(
// log2(CAPACITY)/5) registered levels of the 32-way selection tree (L = 2 at 1024).
// All cells shift in parallel in the commit cycle, so the work per item does not
// grow with the number of stored samples.
// Reset empties the store (count zero) and sets the mode to mean; cell contents
// are not cleared and need no clearing pass.
// A result waits in the output register while the receiver stalls; the next item
// is still accepted and processed up to its commit, which holds until the output
// register frees.
`default_nettype none

module running_median_store #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_wr_en_i,
  input  logic        cfg_wr_data_i,   // median_mode
  // Input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // [63:0] value
  input  logic [2:0]  s_axis_tuser_i,  // [1:0] req_type, [2] value_null
  // Result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // [63:0] median
  output logic [2:0]  m_axis_tuser_o   // [0] empty_res, [2:1] status
);
  import rms_pkg::*;

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TREE_LAT = tree_levels(CAPACITY);
  localparam int WAIT_W   = $clog2(TREE_LAT + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  // Control state
  logic              state_q, state_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              mode_q;
  logic              out_valid_q, out_valid_d;

  // Held item
  logic [1:0]        req_q;
  logic [DATA_W-1:0] item_val_q;
  logic              null_q;

  // Result register
  logic [DATA_W-1:0] out_med_q, out_med_d;
  logic              out_empty_q, out_empty_d;
  logic [1:0]        out_status_q, out_status_d;

  logic              accept;
  logic              finish;
  logic              full;
  logic              found;
  logic [CNT_W:0]    cnt_inc;
  logic [CNT_W-1:0]  lo_idx;
  logic [CNT_W-1:0]  hi_idx;
  logic [DATA_W-1:0] lo_val;
  logic [DATA_W-1:0] hi_val;
  logic [DATA_W-1:0] mean_val;
  logic [TAP_W-1:0]  root;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] cell_val   [CAPACITY];
  nbr_t              cell_flags [CAPACITY];
  logic [TAP_W-1:0]  cell_tap   [CAPACITY];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  // Commit once the tree has settled and the output register is free.
  assign finish = (state_q == ST_BUSY) && (wait_q == '0) &&
                  (!out_valid_q || m_axis_tready_i);

  assign full = cnt_q == CNT_W'(CAPACITY);

  // Middle positions: upper at n/2, lower at (n+1)/2-1; wider sum avoids wrap.
  assign cnt_inc = {1'b0, cnt_q} + {{CNT_W{1'b0}}, 1'b1};
  assign lo_idx  = cnt_q >> 1;
  assign hi_idx  = cnt_inc[CNT_W:1] - {{(CNT_W-1){1'b0}}, 1'b1};

  assign lo_val = root[TAP_W-1 -: DATA_W];
  assign hi_val = root[DATA_W:1];
  assign found  = root[0];

  // Floor of the mean without overflow: halve each, add back the shared low bit.
  assign mean_val = {lo_val[DATA_W-1], lo_val[DATA_W-1:1]} +
                    {hi_val[DATA_W-1], hi_val[DATA_W-1:1]} +
                    {{(DATA_W-1){1'b0}}, lo_val[0] & hi_val[0]};

  // Decide commit strobes and the result of the held item.
  always_comb begin
    ctrl.ins_en  = 1'b0;
    ctrl.rem_en  = 1'b0;
    out_med_d    = '0;
    out_empty_d  = 1'b0;
    out_status_d = STATUS_OK;
    case (req_q)
      REQ_INSERT: begin
        if (!null_q) begin
          if (full) begin
            out_status_d = STATUS_FULL;
          end else begin
            ctrl.ins_en = finish;
          end
        end
      end
      REQ_REMOVE: begin
        if (!null_q) begin
          if (found) begin
            ctrl.rem_en = finish;
          end else begin
            out_status_d = STATUS_NOT_FOUND;
          end
        end
      end
      REQ_QUERY: begin
        if (cnt_q == '0) begin
          out_empty_d = 1'b1;
        end else if (mode_q == MODE_UPPER || cnt_q[0]) begin
          out_med_d = lo_val;
        end else begin
          out_med_d = mean_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins_en) begin
      cnt_d = cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (ctrl.rem_en) begin
      cnt_d = cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  // Sequence: idle until an item arrives, then wait for the tree where needed.
  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_BUSY;
          if (s_axis_tuser_i[1:0] == REQ_REMOVE || s_axis_tuser_i[1:0] == REQ_QUERY) begin
            wait_d = WAIT_W'(TREE_LAT);
          end else begin
            wait_d = '0;
          end
        end
      end
      ST_BUSY: begin
        if (wait_q != '0) begin
          wait_d = wait_q - {{(WAIT_W-1){1'b0}}, 1'b1};
        end else if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= '0;
      cnt_q       <= '0;
      mode_q      <= MODE_MEAN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        mode_q <= cfg_wr_data_i;
      end
    end
  end

  // Hold the item while it is processed; latch the result at commit.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= s_axis_tuser_i[1:0];
      null_q     <= s_axis_tuser_i[2];
      item_val_q <= s_axis_tdata_i;
    end
    if (finish) begin
      out_med_q    <= out_med_d;
      out_empty_q  <= out_empty_d;
      out_status_q <= out_status_d;
    end
  end

  // Sorted chain: cell 0 holds the smallest sample.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    nbr_t              left_flags;
    logic [DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val   = '0;
      assign left_flags = '0;
    end else begin : g_mid
      assign left_val   = cell_val[i-1];
      assign left_flags = cell_flags[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    rms_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .item_val_i   (item_val_q),
      .cnt_i        (cnt_q),
      .lo_idx_i     (lo_idx),
      .hi_idx_i     (hi_idx),
      .left_val_i   (left_val),
      .left_flags_i (left_flags),
      .right_val_i  (right_val),
      .val_o        (cell_val[i]),
      .flags_o      (cell_flags[i]),
      .tap_o        (cell_tap[i])
    );
  end

  rms_or_tree #(
    .N (CAPACITY),
    .W (TAP_W)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_tap),
    .root_o (root)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_med_q;
  assign m_axis_tuser_o  = {out_status_q, out_empty_q};

  // Count never exceeds the number of cells.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("sample count above capacity");

  // Count moves only through a commit strobe.
  a_cnt_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(ctrl.ins_en || ctrl.rem_en))
    else $error("sample count changed without commit");

  // Never insert into a full chain.
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins_en |-> !full)
    else $error("insert committed into full store");

  // Commit only after the tree has settled.
  a_commit_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.ins_en || ctrl.rem_en) |-> (state_q == ST_BUSY && wait_q == '0))
    else $error("commit before selection settled");

  // A pending empty flag means the store is still empty.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> (cnt_q == '0))
    else $error("empty flag with stored samples");

endmodule

`default_nettype wire
